@@ rtl/core/lpht_pkg.sv @@
// Shared types and codes of the linear-probing hash table.
// Holds the microcode step names, control word, branch condition flags
// and request/status codes. No dependencies.
package lpht_pkg;

   // Request kinds carried on req_tuser
   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_INSERT = 1'b1;

   // Result status codes carried on rsp_tuser
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;

   // Microprogram steps (addresses of the control store)
   typedef enum logic [2:0] {
      STEP_CLEAR,
      STEP_IDLE,
      STEP_MUL_Q,
      STEP_MUL_P,
      STEP_FOLD,
      STEP_PROBE,
      STEP_DONE
   } step_type;

   // Branch conditions selectable by a control word
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_CLEAR_END,
      COND_ACCEPT,
      COND_KEY_ZERO,
      COND_PROBE_END,
      COND_OUT_FREE
   } cond_type;

   // One control word of the microprogram
   typedef struct packed {
      logic     ready;      // offer req_tready
      logic     clear;      // write an empty key at the slot pointer
      logic     mul_q;      // quotient estimate: key times reciprocal
      logic     mul_p;      // quotient times capacity
      logic     fold;       // load home slot, start probe
      logic     probe;      // compare one slot per cycle
      logic     finish;     // commit and load the result register
      cond_type cond;
      step_type jump_true;
      step_type jump_false;
   } ctrl_word_type;

   // Condition flags from the datapath to the sequencer
   typedef struct packed {
      logic clear_end;
      logic accept;
      logic key_zero;
      logic probe_end;
      logic out_free;
   } flags_type;

endpackage

@@ rtl/core/linear_probe_hash_table.sv @@
// Linear-probing hash table: request/response streams around a microcoded
// datapath (hash unit, probe pointer, slot storage, result register).
// Depends on lpht_pkg, lpht_seq and lpht_slot_mem.
//
// Usage:
//   req channel: tuser[0] = 0 lookup, 1 insert; tdata = key, value_in.
//   rsp channel: one transaction per request; tdata = value_out, occupancy;
//   tuser = found, status (0 ok, 1 table full, 2 zero key rejected).
//   Home slot is key mod CAPACITY; probing walks up one slot per cycle,
//   wrapping, until a matching key, an empty slot or all slots are seen.
//   The steps are idle (accept), quotient multiply, product multiply,
//   fold, one probe per slot probed (1 to CAPACITY) and done; a zero key
//   skips from the quotient step to done. Time per item is set by the
//   two-multiply hash fold and the single read port of the slot storage,
//   which the probe loop visits once per cycle. Done loads the output
//   register once it is free. After reset a clearing pass writes every
//   key slot empty, with req_tready low. A stalled response is held in
//   the output register while the next request is taken and processed;
//   that request waits at its final step until the register is free.
module linear_probe_hash_table #(
   parameter int CAPACITY   = 256,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] key, [63:32] value_in
   input  logic [0:0]  req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] value_out, [40:32] occupancy, zero fill
   output logic [2:0]  rsp_tuser    // [0] found, [2:1] status
);

   localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
   localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [31:0] CAP_W = 32'(CAPACITY);
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / CAPACITY);
   localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

   lpht_pkg::ctrl_word_type ctrl;
   lpht_pkg::flags_type     flags;

   // Request registers
   logic          type_ff;
   logic [KW-1:0] key_ff;
   logic [VW-1:0] val_ff;
   logic [31:0]   key32;
   logic          accept;
   logic          key_zero;

   // Hash unit
   logic [63:0] q_prod;
   logic [31:0] q_ff;
   logic [31:0] p_prod;
   logic [31:0] p_ff;
   logic [31:0] rem;
   logic [31:0] rem_fix;
   logic [AW-1:0] home;

   // Probe state
   logic [AW-1:0] ptr_ff, ptr_in, ptr_wrap;
   logic [AW-1:0] seen_ff, seen_in;
   logic          hit_ff, empty_ff;
   logic          match, slot_empty, seen_last, probe_end;

   // Slot storage
   logic [KW-1:0] rd_key;
   logic [VW-1:0] rd_val;
   logic [KW-1:0] wr_key;
   logic          key_we, val_we;

   // Commit and count
   logic          out_free, commit, new_key;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0]   cnt_ext;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff;
   logic        rsp_found_ff;
   logic [1:0]  rsp_status_ff;
   logic [8:0]  rsp_occ_ff;
   logic [31:0] value_res;
   logic [1:0]  status_res;

   lpht_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   lpht_slot_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW),
      .KW    (KW),
      .VW    (VW)
   ) u_slot_mem (
      .clock   (clock),
      .key_we  (key_we),
      .val_we  (val_we),
      .wr_addr (ptr_ff),
      .wr_key  (wr_key),
      .wr_val  (val_ff),
      .rd_addr (ptr_in),
      .rd_key  (rd_key),
      .rd_val  (rd_val)
   );

   // Input handshake
   assign req_tready = ctrl.ready;
   assign accept     = req_tvalid && req_tready;

   // Capture the request transaction (the probe outcome is cleared in the probe state block)
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_tuser[0];
         key_ff  <= req_tdata[KW-1:0];
         val_ff  <= req_tdata[32 +: VW];
      end
   end

   assign key32    = 32'(key_ff);
   assign key_zero = (key_ff == '0);

   // Hash: quotient estimate by reciprocal, remainder with one correction
   assign q_prod  = key32 * RECIP;
   assign p_prod  = q_ff * CAP_W;
   assign rem     = key32 - p_ff;
   assign rem_fix = (rem >= CAP_W) ? (rem - CAP_W) : rem;
   assign home    = rem_fix[AW-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.mul_q) begin
         q_ff <= q_prod[63:32];
      end
      if (ctrl.mul_p) begin
         p_ff <= p_prod;
      end
   end

   // Probe compare on the slot read last cycle
   assign match      = (rd_key == key_ff);
   assign slot_empty = (rd_key == '0);
   assign seen_last  = (seen_ff == LAST_SLOT);
   assign probe_end  = match || slot_empty || seen_last;
   assign ptr_wrap   = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + 1'b1;

   // Advance the slot pointer; its next value also addresses the read port
   always_comb begin
      ptr_in  = ptr_ff;
      seen_in = seen_ff;
      if (ctrl.clear) begin
         ptr_in = ptr_wrap;
      end else if (ctrl.fold) begin
         ptr_in  = home;
         seen_in = '0;
      end else if (ctrl.probe && !probe_end) begin
         ptr_in  = ptr_wrap;
         seen_in = seen_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         seen_ff  <= '0;
         hit_ff   <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         seen_ff <= seen_in;
         if (accept) begin
            hit_ff   <= 1'b0;
            empty_ff <= 1'b0;
         end else if (ctrl.probe) begin
            hit_ff   <= match;
            empty_ff <= slot_empty;
         end
      end
   end

   // Commit: write slot, bump count, load result
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign commit   = ctrl.finish && out_free;
   assign new_key  = commit && (type_ff == lpht_pkg::REQ_INSERT) && empty_ff;
   assign val_we   = commit && (type_ff == lpht_pkg::REQ_INSERT) && (hit_ff || empty_ff);
   assign key_we   = ctrl.clear || new_key;
   assign wr_key   = ctrl.clear ? '0 : key_ff;
   assign cnt_in   = cnt_ff + CW'(new_key);
   assign cnt_ext  = 32'(cnt_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Result fields
   always_comb begin
      value_res = '0;
      if ((type_ff == lpht_pkg::REQ_LOOKUP) && hit_ff) begin
         value_res = 32'(rd_val);
      end
      if (key_zero) begin
         status_res = lpht_pkg::STATUS_ZERO;
      end else if ((type_ff == lpht_pkg::REQ_INSERT) && !hit_ff && !empty_ff) begin
         status_res = lpht_pkg::STATUS_FULL;
      end else begin
         status_res = lpht_pkg::STATUS_OK;
      end
   end

   // Output register: hold until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_value_ff  <= value_res;
         rsp_found_ff  <= hit_ff;
         rsp_status_ff <= status_res;
         rsp_occ_ff    <= cnt_ext[8:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_occ_ff, rsp_value_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_found_ff};

   // Branch flags to the sequencer
   always_comb begin
      flags.clear_end = (ptr_ff == LAST_SLOT);
      flags.accept    = accept;
      flags.key_zero  = key_zero;
      flags.probe_end = probe_end;
      flags.out_free  = out_free;
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_cnt_source: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |-> ($past(new_key) || $past(reset)))
      else $error("entry count changed without a new key");

   a_outcome_excl: assert property (@(posedge clock) disable iff (reset)
      !(hit_ff && empty_ff))
      else $error("probe ended both on a match and an empty slot");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      commit |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result loaded over a pending response");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= LAST_SLOT)
      else $error("slot pointer out of range");
`endif

endmodule

@@ rtl/core/lpht_slot_mem.sv @@
// Slot storage of the hash table: key array and value array.
// One write port, one read port with registered read data.
// Depends on nothing; widths come from the instantiating module.
module lpht_slot_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int KW    = 32,
   parameter int VW    = 32
) (
   input  logic          clock,
   input  logic          key_we,
   input  logic          val_we,
   input  logic [AW-1:0] wr_addr,
   input  logic [KW-1:0] wr_key,
   input  logic [VW-1:0] wr_val,
   input  logic [AW-1:0] rd_addr,
   output logic [KW-1:0] rd_key,
   output logic [VW-1:0] rd_val
);

   logic [KW-1:0] key_mem [DEPTH];
   logic [VW-1:0] val_mem [DEPTH];

   // Write key and value at the write address
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (val_we) begin
         val_mem[wr_addr] <= wr_val;
      end
   end

   // Read every cycle, data registered
   always_ff @(posedge clock) begin
      rd_key <= key_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
   end

endmodule

@@ rtl/core/lpht_seq.sv @@
// Microcode sequencer: step counter, control store and branch unit.
// Depends on lpht_pkg for the step, condition and control word types.
module lpht_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  lpht_pkg::flags_type    flags,
   output lpht_pkg::ctrl_word_type ctrl
);

   lpht_pkg::step_type step_ff;
   lpht_pkg::step_type step_in;
   logic               cond_hit;

   // Control store: one word per step
   function automatic lpht_pkg::ctrl_word_type ucode(input lpht_pkg::step_type s);
      lpht_pkg::ctrl_word_type w;
      w = '0;
      w.cond       = lpht_pkg::COND_ALWAYS;
      w.jump_true  = lpht_pkg::STEP_IDLE;
      w.jump_false = lpht_pkg::STEP_IDLE;
      case (s)
         lpht_pkg::STEP_CLEAR: begin
            w.clear      = 1'b1;
            w.cond       = lpht_pkg::COND_CLEAR_END;
            w.jump_true  = lpht_pkg::STEP_IDLE;
            w.jump_false = lpht_pkg::STEP_CLEAR;
         end
         lpht_pkg::STEP_IDLE: begin
            w.ready      = 1'b1;
            w.cond       = lpht_pkg::COND_ACCEPT;
            w.jump_true  = lpht_pkg::STEP_MUL_Q;
            w.jump_false = lpht_pkg::STEP_IDLE;
         end
         lpht_pkg::STEP_MUL_Q: begin
            w.mul_q      = 1'b1;
            w.cond       = lpht_pkg::COND_KEY_ZERO;
            w.jump_true  = lpht_pkg::STEP_DONE;
            w.jump_false = lpht_pkg::STEP_MUL_P;
         end
         lpht_pkg::STEP_MUL_P: begin
            w.mul_p      = 1'b1;
            w.jump_true  = lpht_pkg::STEP_FOLD;
         end
         lpht_pkg::STEP_FOLD: begin
            w.fold       = 1'b1;
            w.jump_true  = lpht_pkg::STEP_PROBE;
         end
         lpht_pkg::STEP_PROBE: begin
            w.probe      = 1'b1;
            w.cond       = lpht_pkg::COND_PROBE_END;
            w.jump_true  = lpht_pkg::STEP_DONE;
            w.jump_false = lpht_pkg::STEP_PROBE;
         end
         lpht_pkg::STEP_DONE: begin
            w.finish     = 1'b1;
            w.cond       = lpht_pkg::COND_OUT_FREE;
            w.jump_true  = lpht_pkg::STEP_IDLE;
            w.jump_false = lpht_pkg::STEP_DONE;
         end
         default: begin
            w.jump_true  = lpht_pkg::STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // Output: fetch the control word of the current step
   always_comb begin
      ctrl = ucode(step_ff);
   end

   // Next step: evaluate the branch condition
   always_comb begin
      case (ctrl.cond)
         lpht_pkg::COND_ALWAYS:    cond_hit = 1'b1;
         lpht_pkg::COND_CLEAR_END: cond_hit = flags.clear_end;
         lpht_pkg::COND_ACCEPT:    cond_hit = flags.accept;
         lpht_pkg::COND_KEY_ZERO:  cond_hit = flags.key_zero;
         lpht_pkg::COND_PROBE_END: cond_hit = flags.probe_end;
         lpht_pkg::COND_OUT_FREE:  cond_hit = flags.out_free;
         default:                  cond_hit = 1'b1;
      endcase
      step_in = cond_hit ? ctrl.jump_true : ctrl.jump_false;
   end

   // Step counter; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lpht_pkg::STEP_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ bench/lpht_checker.sv @@
// Response checker for the linear-probing hash table bench.
// Watches both stream channels, keeps its own copy of the table and compares
// every response field by field. Depends on lpht_pkg.
module lpht_checker #(
   parameter int CAPACITY = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [63:0]       req_tdata,   // [31:0] key, [63:32] value_in
   input  logic [0:0]        req_tuser,   // [0] req_type
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [47:0]       rsp_tdata,   // [31:0] value_out, [40:32] occupancy, zero fill
   input  logic [2:0]        rsp_tuser,   // [0] found, [2:1] status
   output int unsigned       mismatches,
   output int unsigned       awaiting
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] value;
      logic        found;
      logic [1:0]  status;
      logic [8:0]  occupancy;
   } table_answer_type;

   // Shadow copy of the slot storage
   logic [31:0]      slot_key   [CAPACITY];
   logic [31:0]      slot_value [CAPACITY];
   int unsigned      stored_keys;
   table_answer_type answers_due [$];

   // Walk the shadow table from the home slot and apply one request to it
   function automatic table_answer_type apply_request(logic kind, logic [31:0] key,
                                                      logic [31:0] value);
      table_answer_type answer;
      int unsigned      slot;
      int unsigned      seen;
      bit               hit;
      bit               empty;
      answer        = '0;
      answer.status = lpht_pkg::STATUS_OK;
      if (key == '0) begin
         answer.status = lpht_pkg::STATUS_ZERO;
      end else begin
         slot = key % CAPACITY;
         seen = 0;
         while (seen < CAPACITY && slot_key[slot] != key && slot_key[slot] != '0) begin
            slot = (slot + 1) % CAPACITY;
            seen++;
         end
         hit   = (seen < CAPACITY) && (slot_key[slot] == key);
         empty = (seen < CAPACITY) && (slot_key[slot] == '0);
         if (kind == lpht_pkg::REQ_LOOKUP) begin
            if (hit) begin
               answer.value = slot_value[slot];
               answer.found = 1'b1;
            end
         end else if (hit) begin
            slot_value[slot] = value;
            answer.found     = 1'b1;
         end else if (empty) begin
            slot_key[slot]   = key;
            slot_value[slot] = value;
            stored_keys++;
         end else begin
            answer.status = lpht_pkg::STATUS_FULL;
         end
      end
      answer.occupancy = stored_keys[8:0];
      return answer;
   endfunction

   // Retire responses against the oldest prediction, then predict new requests
   always @(posedge clock) begin : watch
      table_answer_type due;
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) slot_key[i] = '0;
         stored_keys = 0;
         answers_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               $error("response with no request outstanding: tdata %h, tuser %h",
                      rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_tdata[31:0] !== due.value) begin
                  $error("value_out: expected %h, actual %h", due.value, rsp_tdata[31:0]);
                  mismatches++;
               end
               if (rsp_tuser[0] !== due.found) begin
                  $error("found: expected %0d, actual %0d", due.found, rsp_tuser[0]);
                  mismatches++;
               end
               if (rsp_tuser[2:1] !== due.status) begin
                  $error("status: expected %0d, actual %0d", due.status, rsp_tuser[2:1]);
                  mismatches++;
               end
               if (rsp_tdata[40:32] !== due.occupancy) begin
                  $error("occupancy: expected %0d, actual %0d", due.occupancy,
                         rsp_tdata[40:32]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            answers_due.push_back(apply_request(req_tuser[0], req_tdata[31:0],
                                                req_tdata[63:32]));
         end
      end
      awaiting = answers_due.size();
   end

endmodule

@@ bench/tb.sv @@
// Top of the hash table bench: clock, reset, request stimulus, response
// back-pressure, watchdog and verdict. Depends on lpht_pkg, lpht_checker
// and linear_probe_hash_table.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY       = 256;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 600;
   localparam int SETTLE_CYCLES  = 300;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   int unsigned mismatches;
   int unsigned awaiting;
   logic        squeeze;   // ask the response side for one long hold-off
   logic        calm;      // no idling on either side from here on

   // Keys the table holds, as seen from the request side
   logic [31:0] table_keys [$];

   linear_probe_hash_table #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (32),
      .VALUE_BITS (32)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lpht_checker #(
      .CAPACITY (CAPACITY)
   ) table_watch (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit is_stored(logic [31:0] key);
      foreach (table_keys[i]) if (table_keys[i] == key) return 1'b1;
      return 1'b0;
   endfunction

   // Nonzero key not in the table; homes are often packed around the wrap point
   function automatic logic [31:0] fresh_key();
      logic [31:0] key;
      int unsigned pick;
      int unsigned hot;
      do begin
         pick = $urandom_range(0, 9);
         key  = $urandom;
         if (pick >= 4 && pick <= 7) begin
            hot       = $urandom_range(0, 7);
            key[7:0]  = (hot < 4) ? 8'(252 + hot) : 8'(hot - 4);
         end
      end while (key == '0 || is_stored(key));
      return key;
   endfunction

   function automatic logic [31:0] held_key();
      if (table_keys.size() == 0) return fresh_key();
      return table_keys[$urandom_range(0, table_keys.size() - 1)];
   endfunction

   function automatic logic [31:0] any_value();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return $urandom;
   endfunction

   // Offer one request and hold it until the transaction completes
   task automatic send(logic kind, logic [31:0] key, logic [31:0] value);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {value, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == lpht_pkg::REQ_INSERT && key != '0 && !is_stored(key) &&
          table_keys.size() < CAPACITY)
         table_keys.push_back(key);
   endtask

   // One random request drawn by weight: zero key, hit, overwrite, miss, new insert
   task automatic mixed_item(int unsigned w_zero, int unsigned w_hit, int unsigned w_over,
                             int unsigned w_miss, int unsigned w_new);
      int unsigned roll;
      roll = $urandom_range(0, w_zero + w_hit + w_over + w_miss + w_new - 1);
      if (roll < w_zero)
         send(logic'($urandom_range(0, 1)), '0, any_value());
      else if (roll < w_zero + w_hit)
         send(lpht_pkg::REQ_LOOKUP, held_key(), any_value());
      else if (roll < w_zero + w_hit + w_over)
         send(lpht_pkg::REQ_INSERT, held_key(), any_value());
      else if (roll < w_zero + w_hit + w_over + w_miss)
         send(lpht_pkg::REQ_LOOKUP, fresh_key(), any_value());
      else
         send(lpht_pkg::REQ_INSERT, fresh_key(), any_value());
   endtask

   initial begin : stimulus
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= lpht_pkg::REQ_LOOKUP;
      squeeze    <= 1'b0;
      calm       <= 1'b0;
      reset      <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Zero key on both operations, then a miss on an empty table
      send(lpht_pkg::REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send(lpht_pkg::REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
      send(lpht_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // Cluster at the last slot that wraps around to slot 0 and beyond
      send(lpht_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(lpht_pkg::REQ_INSERT, 32'h0000_01FF, 32'h0000_0000);
      send(lpht_pkg::REQ_INSERT, 32'h0000_0100, 32'h1234_5678);
      send(lpht_pkg::REQ_LOOKUP, 32'h0000_0100, 32'h0000_0000);
      send(lpht_pkg::REQ_LOOKUP, 32'h0000_01FF, 32'hFFFF_FFFF);
      // Overwrite, then read back the new value
      send(lpht_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
      send(lpht_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      // Miss that walks the whole cluster before the empty slot
      send(lpht_pkg::REQ_LOOKUP, 32'h0000_02FF, 32'h0000_0000);
      send(lpht_pkg::REQ_INSERT, 32'h0000_0001, 32'hA5A5_A5A5);
      send(lpht_pkg::REQ_LOOKUP, 32'h0000_0001, 32'h5A5A_5A5A);
      send(lpht_pkg::REQ_INSERT, 32'h8000_0000, 32'h8000_0000);
      send(lpht_pkg::REQ_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF);
      send(lpht_pkg::REQ_INSERT, 32'h7FFF_FF80, 32'h7FFF_FFFF);
      send(lpht_pkg::REQ_LOOKUP, 32'h7FFF_FF80, 32'h0000_0000);

      // Grow the table gradually with a broad mix
      for (int n = 0; n < 700; n++) begin
         if (n == 300) squeeze <= 1'b1;
         mixed_item(4, 30, 16, 25, 25);
      end
      // Fill the remaining slots
      while (table_keys.size() < CAPACITY) mixed_item(4, 8, 8, 5, 75);
      // Full table: rejected inserts, full-length misses, hits and overwrites
      for (int n = 0; n < 550; n++) begin
         if (n == 400) calm <= 1'b1;
         mixed_item(5, 30, 20, 25, 20);
      end
      req_tvalid <= 1'b0;

      // Drain, then give a late stray response time to show up
      do @(negedge clock); while (awaiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   // Response side: random stalls, ready stretches, one long hold-off
   initial begin : response_side
      bit held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (squeeze && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   // End the run if no transaction moves on either channel for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: errors");
      $finish;
   end

endmodule
